// ----- rtl/core/stt_pkg.sv -----
`default_nettype none

package stt_pkg;

   localparam int TIMER_SLOTS  = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int IDX_W        = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W        = $clog2(TIMER_SLOTS + 1);
   localparam int RCNT_W       = $clog2(RESULT_LIMIT + 1);
   localparam int HANDLE_W     = 5;
   localparam int SLOT_W       = 4;
   localparam logic [HANDLE_W-1:0] NO_HANDLE = 5'd16;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ONESHOT  = 2'd1,
      OP_PERIODIC = 2'd2,
      OP_DELETE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_GRANT = 2'd0,
      KIND_FIRED = 2'd1,
      KIND_FULL  = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] wait_length;
      logic [31:0] repeat_period;
   } slot_entry_type;

   typedef struct packed {
      logic           en;
      logic [IDX_W-1:0] addr;
      slot_entry_type data;
   } mem_wr_type;

   typedef struct packed {
      logic           en;
      logic [IDX_W-1:0] addr;
   } mem_rd_type;

endpackage

`default_nettype wire

// ----- rtl/core/stt_slot_mem.sv -----
`default_nettype none

// Slot timing store: one write port, one read port, registered read data.
module stt_slot_mem
   import stt_pkg::*;
(
   input  wire logic           clock,
   input  wire mem_wr_type     wr,
   input  wire mem_rd_type     rd,
   output slot_entry_type      rd_data
);

   slot_entry_type mem [TIMER_SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/software_timer_table.sv -----
// Software timer table: sixteen timer slots driven by a request stream.
// The req channel carries one command per transfer: tick, schedule one-shot,
// schedule periodic or delete. The rsp channel returns result transfers;
// the final result of every command has rsp_tlast high.
// A schedule or delete moves to the flush state, which loads its result into
// the result register once that register is free; req_tready returns as the
// result is loaded. A schedule claims the lowest free slot and writes it to
// slot memory, or answers full if no slot is free. A tick walks the slot
// memory one entry per cycle unless stalled, with registered read data, and
// the next request is taken once its final result is loaded. A firing
// periodic slot is rewritten while the next one is read; one-shots disarm.
// Firings are reported in slot order; the last one seen is held back so that
// it can be marked as final once the walk ends. A tick that fires nothing
// answers a single done result.
// One command is in work at a time: req_tready is high only while idle.
// When the receiver stalls, the result register holds its transfer and the
// walk pauses at the next firing slot until the register drains.
// Reset (synchronous, active high) frees and disarms every slot and empties
// the result register; slot memory contents are only used for armed slots,
// so the memory needs no clearing pass.
`default_nettype none

module software_timer_table
   import stt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // [31:0] now_ms, [63:32] delay_ms, [64] stagger_enable,
   // [96:65] stagger_ms, [101:97] handle, [103:102] zero
   input  wire logic [103:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [3:0] slot, [7:4] zero
   output      logic [7:0]   rsp_tdata,
   // [1:0] kind
   output      logic [1:0]   rsp_tuser,
   output      logic         rsp_tlast
);

   // Request fields.
   logic [31:0]         req_now_ms;
   logic [31:0]         req_delay_ms;
   logic                req_stagger_enable;
   logic [31:0]         req_stagger_ms;
   logic [HANDLE_W-1:0] req_handle;
   op_type              req_operation;

   assign req_now_ms         = req_tdata[31:0];
   assign req_delay_ms       = req_tdata[63:32];
   assign req_stagger_enable = req_tdata[64];
   assign req_stagger_ms     = req_tdata[96:65];
   assign req_handle         = req_tdata[101:97];
   assign req_operation      = op_type'(req_tuser);

   // Control state.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic [31:0]          now_ff, now_in;
   logic [TIMER_SLOTS-1:0] armed_ff, armed_in;
   logic [TIMER_SLOTS-1:0] in_use_ff, in_use_in;
   logic                 pend_vld_ff, pend_vld_in;
   kind_type             pend_kind_ff, pend_kind_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [RCNT_W-1:0]    rpt_cnt_ff, rpt_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_last_ff, rsp_last_in;

   mem_wr_type           mem_wr;
   mem_rd_type           mem_rd;
   slot_entry_type       rd_data;

   stt_slot_mem u_slot_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   // Lowest free slot.
   logic             free_found;
   logic [IDX_W-1:0] free_idx;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Evaluation of the slot whose entry was read most recently.
   logic [31:0] elapsed;
   logic        fire;
   logic        report;
   logic        out_free;
   logic        stall;
   logic        handle_ok;
   logic [IDX_W-1:0] del_idx;
   logic [31:0] sched_wait;
   logic [31:0] sched_period;

   assign elapsed   = now_ff - rd_data.start_time;
   assign fire      = ev_vld_ff && armed_ff[ev_idx_ff] && (elapsed >= rd_data.wait_length);
   assign report    = fire && (rpt_cnt_ff != RCNT_W'(RESULT_LIMIT));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign stall     = report && pend_vld_ff && !out_free;
   assign handle_ok = (req_handle != NO_HANDLE) && (32'(req_handle) < 32'(TIMER_SLOTS));
   assign del_idx   = IDX_W'(req_handle);

   always_comb begin
      sched_wait   = req_delay_ms;
      sched_period = '0;
      if (req_operation == OP_PERIODIC) begin
         sched_period = req_delay_ms;
         if (req_stagger_enable) begin
            sched_wait = req_delay_ms + req_stagger_ms;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      ev_vld_in    = ev_vld_ff;
      ev_idx_in    = ev_idx_ff;
      now_in       = now_ff;
      armed_in     = armed_ff;
      in_use_in    = in_use_ff;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_slot_in = pend_slot_ff;
      rpt_cnt_in   = rpt_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr       = '0;
      mem_rd       = '0;
      req_tready   = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_operation)
                  OP_TICK: begin
                     now_in      = req_now_ms;
                     rd_cnt_in   = '0;
                     ev_vld_in   = 1'b0;
                     pend_vld_in = 1'b0;
                     rpt_cnt_in  = '0;
                     state_in    = ST_SCAN;
                  end
                  OP_ONESHOT, OP_PERIODIC: begin
                     pend_vld_in = 1'b1;
                     if (free_found) begin
                        mem_wr.en                 = 1'b1;
                        mem_wr.addr               = free_idx;
                        mem_wr.data.start_time    = req_now_ms;
                        mem_wr.data.wait_length   = sched_wait;
                        mem_wr.data.repeat_period = sched_period;
                        armed_in[free_idx]        = 1'b1;
                        in_use_in[free_idx]       = 1'b1;
                        pend_kind_in              = KIND_GRANT;
                        pend_slot_in              = SLOT_W'(free_idx);
                     end else begin
                        pend_kind_in = KIND_FULL;
                        pend_slot_in = '0;
                     end
                     state_in = ST_FLUSH;
                  end
                  OP_DELETE: begin
                     if (handle_ok) begin
                        armed_in[del_idx]  = 1'b0;
                        in_use_in[del_idx] = 1'b0;
                     end
                     pend_vld_in = 1'b0;
                     state_in    = ST_FLUSH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               if (fire) begin
                  if (rd_data.repeat_period != '0) begin
                     mem_wr.en                 = 1'b1;
                     mem_wr.addr               = ev_idx_ff;
                     mem_wr.data.start_time    = now_ff;
                     mem_wr.data.wait_length   = rd_data.repeat_period;
                     mem_wr.data.repeat_period = rd_data.repeat_period;
                  end else begin
                     armed_in[ev_idx_ff] = 1'b0;
                  end
               end
               if (report) begin
                  // The previous firing is now known not to be the final one.
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_slot_in  = pend_slot_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_kind_in = KIND_FIRED;
                  pend_slot_in = SLOT_W'(ev_idx_ff);
                  rpt_cnt_in   = rpt_cnt_ff + 1'b1;
               end
               mem_rd.en   = (rd_cnt_ff != CNT_W'(TIMER_SLOTS));
               mem_rd.addr = rd_cnt_ff[IDX_W-1:0];
               ev_vld_in   = mem_rd.en;
               ev_idx_in   = rd_cnt_ff[IDX_W-1:0];
               if (mem_rd.en) begin
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
               if (ev_vld_ff && (ev_idx_ff == IDX_W'(TIMER_SLOTS - 1))) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_vld_ff) begin
                  rsp_kind_in = pend_kind_ff;
                  rsp_slot_in = pend_slot_ff;
               end else begin
                  rsp_kind_in = KIND_DONE;
                  rsp_slot_in = '0;
               end
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         ev_vld_ff    <= 1'b0;
         armed_ff     <= '0;
         in_use_ff    <= '0;
         pend_vld_ff  <= 1'b0;
         rpt_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         ev_vld_ff    <= ev_vld_in;
         armed_ff     <= armed_in;
         in_use_ff    <= in_use_in;
         pend_vld_ff  <= pend_vld_in;
         rpt_cnt_ff   <= rpt_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ev_idx_ff    <= ev_idx_in;
      now_ff       <= now_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/stt_checker.sv -----
`default_nettype none

module stt_checker
   import stt_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [7:0]   rsp_tdata,
   input wire logic [1:0]   rsp_tuser,
   input wire logic         rsp_tlast
);

   // Out of reset the block is idle with nothing to deliver.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   // One command at a time: an accepted request closes the input side.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in work");

   // Grants, full reports and done reports are always the final result.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_GRANT || rsp_tuser == KIND_FULL ||
                      rsp_tuser == KIND_DONE)) |-> rsp_tlast)
      else $error("single result not marked last");

   // Done and full reports carry slot zero.
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_FULL))
         |-> (rsp_tdata == 8'd0))
      else $error("nonzero slot on done or full result");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

endmodule

bind software_timer_table stt_checker u_stt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
